FILE: rtl/core/bkc_pkg.sv
// shared constants and types for the collision backoff checker
package bkc_pkg;

    localparam int NODES_DEF              = 16;
    localparam int TABLE_ENTRIES_DEF      = 256;
    localparam int RECORDS_PER_BUCKET_DEF = 4;

    localparam int TIME_W    = 16;
    localparam int GUARD_W   = 15;
    localparam int NIB_W     = 4;
    localparam int PAIR_W    = 8;
    localparam int TYPE_W    = 2;
    localparam int BACKOFF_W = 17;
    localparam int REC_W     = PAIR_W + TYPE_W + TIME_W;

    // func codes
    localparam logic [1:0] FN_WRITE_DELAY = 2'd0;
    localparam logic [1:0] FN_ADD_RECORD  = 2'd1;
    localparam logic [1:0] FN_CHECK       = 2'd2;
    localparam logic [1:0] FN_CLEAR_ALL   = 2'd3;

    // frame types
    localparam logic [TYPE_W-1:0] FT_RTS  = 2'd0;
    localparam logic [TYPE_W-1:0] FT_CTS  = 2'd1;
    localparam logic [TYPE_W-1:0] FT_DATA = 2'd2;
    localparam logic [TYPE_W-1:0] FT_ACK  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd0;
    localparam logic [1:0] REG_MAX_PROP      = 2'd1;
    localparam logic [1:0] REG_CTRL_GUARD    = 2'd2;
    localparam logic [1:0] REG_DATA_GUARD    = 2'd3;

    localparam logic [NIB_W-1:0]   LOCAL_ADDRESS_RST = 4'd1;
    localparam logic [TIME_W-1:0]  MAX_PROP_RST      = 16'd1000;
    localparam logic [GUARD_W-1:0] CTRL_GUARD_RST    = 15'd100;
    localparam logic [GUARD_W-1:0] DATA_GUARD_RST    = 15'd200;

    localparam logic [TIME_W+1:0] BACKOFF_BIAS = 18'd5;

    typedef struct packed {
        logic                 hit;
        logic                 stale;
        logic [BACKOFF_W-1:0] backoff;
    } win_res_t;

endpackage

FILE: rtl/core/bkc_ram.sv
// generic single write port ram with registered read
module bkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bkc_window.sv
// arrival window test on 16-bit wrapping times
module bkc_window import bkc_pkg::*; (
    input  logic [TIME_W-1:0]  a,
    input  logic [TIME_W-1:0]  b,
    input  logic [GUARD_W-1:0] lo,
    input  logic [GUARD_W-1:0] hi,
    output win_res_t           res
);

    logic [TIME_W-1:0] diff;
    logic [TIME_W+1:0] d_ext;
    logic [TIME_W+1:0] above;
    logic [TIME_W+1:0] below;
    logic [TIME_W+1:0] biased;

    assign diff   = a - b;
    assign d_ext  = {{2{diff[TIME_W-1]}}, diff};
    // hi - d, negative when d is past the window
    assign above  = {3'b000, hi} - d_ext;
    // d + lo, negative when d is before the window
    assign below  = d_ext + {3'b000, lo};
    assign biased = above + BACKOFF_BIAS;

    assign res.stale   = above[TIME_W+1];
    assign res.hit     = !above[TIME_W+1] && !below[TIME_W+1];
    assign res.backoff = biased[BACKOFF_W-1:0];

endmodule

FILE: rtl/core/mac_collision_backoff_checker.sv
// top level: register port, record scan sequencer and state memories
// write delay and clear all go straight to the finish state; add record reads the bucket fill, then
// writes the record and the new fill; check reads the delay, then per bucket reads the fill and per record
//   reads the record and two delays, runs the window steps and shifts later records down on a retire
// one transaction is in work at a time; the record scan and the output stall set the rate
// reset sets the configuration registers to defaults and empties delay and fill tables at once via valid bits
module mac_collision_backoff_checker import bkc_pkg::*; #(
    parameter int NODES              = NODES_DEF,
    parameter int TABLE_ENTRIES      = TABLE_ENTRIES_DEF,
    parameter int RECORDS_PER_BUCKET = RECORDS_PER_BUCKET_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [PAIR_W-1:0]    pair_addr,
    input  logic [TYPE_W-1:0]    frame_type,
    input  logic [TIME_W-1:0]    record_time,
    input  logic [TIME_W-1:0]    current_time,
    input  logic [TIME_W-1:0]    delay_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BACKOFF_W-1:0] backoff,
    output logic                 status
);

    localparam int IW        = $clog2(TABLE_ENTRIES);
    localparam int FW        = $clog2(RECORDS_PER_BUCKET + 1);
    localparam int REC_DEPTH = TABLE_ENTRIES * RECORDS_PER_BUCKET;
    localparam int RAW       = $clog2(REC_DEPTH);
    localparam int PAIRS     = 256;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_WR = 4'd1;
    localparam logic [3:0] S_CHK1   = 4'd2;
    localparam logic [3:0] S_BKT    = 4'd3;
    localparam logic [3:0] S_FILL   = 4'd4;
    localparam logic [3:0] S_RECA   = 4'd5;
    localparam logic [3:0] S_RECB   = 4'd6;
    localparam logic [3:0] S_DO     = 4'd7;
    localparam logic [3:0] S_DL     = 4'd8;
    localparam logic [3:0] S_STEP   = 4'd9;
    localparam logic [3:0] S_RET    = 4'd10;
    localparam logic [3:0] S_RETW   = 4'd11;
    localparam logic [3:0] S_FINISH = 4'd12;

    function automatic logic [PAIRS*IW-1:0] build_hash_lut();
        logic [PAIRS*IW-1:0] lut;
        int                  v;
        lut = '0;
        for (int p = 0; p < PAIRS; p++)
        begin
            v = (((p & 'hf0) >> 4) * NODES + (p & 'h0f) + 2 * TABLE_ENTRIES - NODES - 2)
                % TABLE_ENTRIES;
            lut[p*IW +: IW] = IW'(v);
        end
        return lut;
    endfunction

    localparam logic [PAIRS*IW-1:0] HASH_LUT = build_hash_lut();

    function automatic logic [IW-1:0] hash_of(input logic [PAIR_W-1:0] p);
        return HASH_LUT[int'(p)*IW +: IW];
    endfunction

    function automatic logic [RAW-1:0] rec_addr(input logic [IW-1:0] bkt,
                                                input logic [FW-1:0] pos);
        return RAW'(RAW'(bkt) * RAW'(RECORDS_PER_BUCKET)) + RAW'(pos);
    endfunction

    // control registers
    logic [3:0]               state_reg, state_next;
    logic [NIB_W-1:0]         local_address_reg;
    logic [TIME_W-1:0]        max_prop_reg;
    logic [GUARD_W-1:0]       ctrl_guard_reg;
    logic [GUARD_W-1:0]       data_guard_reg;
    logic [TABLE_ENTRIES-1:0] dvalid_reg, dvalid_next;
    logic [TABLE_ENTRIES-1:0] fvalid_reg, fvalid_next;
    logic                     dvq_reg, fvq_reg;
    logic                     out_valid_reg, out_valid_next;

    // payload registers
    logic [PAIR_W-1:0]    pair_reg, pair_next;
    logic [TYPE_W-1:0]    type_reg, type_next;
    logic [TIME_W-1:0]    rtime_reg, rtime_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    p2_reg, p2_next;
    logic [TIME_W-1:0]    p3_reg, p3_next;
    logic [TIME_W-1:0]    alc_reg, alc_next;
    logic [TIME_W-1:0]    ala_reg, ala_next;
    logic [IW-1:0]        bucket_reg, bucket_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        j_reg, j_next;
    logic [FW-1:0]        k_reg, k_next;
    logic [REC_W-1:0]     rec_reg, rec_next;
    logic [TIME_W-1:0]    do_reg, do_next;
    logic [TIME_W-1:0]    lar_reg, lar_next;
    logic [TIME_W-1:0]    lad_reg, lad_next;
    logic [TIME_W-1:0]    x1_reg, x1_next;
    logic [TIME_W-1:0]    x2_reg, x2_next;
    logic [2:0]           step_reg, step_next;
    logic [BACKOFF_W-1:0] res_backoff_reg, res_backoff_next;
    logic                 res_status_reg, res_status_next;
    logic [BACKOFF_W-1:0] backoff_reg, backoff_next;
    logic                 status_reg, status_next;

    // memory ports
    logic              d_we;
    logic [IW-1:0]     d_waddr, d_raddr;
    logic [TIME_W-1:0] d_wdata, d_rdata;
    logic              f_we;
    logic [IW-1:0]     f_waddr, f_raddr;
    logic [FW-1:0]     f_wdata, f_rdata;
    logic              r_we;
    logic [RAW-1:0]    r_waddr, r_raddr;
    logic [REC_W-1:0]  r_wdata, r_rdata;

    logic [TIME_W-1:0]  delay_rd;
    logic [FW-1:0]      fill_rd;
    logic [PAIR_W-1:0]  rec_pair;
    logic [TYPE_W-1:0]  rec_type;
    logic [TIME_W-1:0]  rec_time;
    logic [PAIR_W-1:0]  rd_pair;
    logic [TIME_W-1:0]  win_a, win_b;
    logic [GUARD_W-1:0] win_lo, win_hi;
    logic               stale_step, last_step;
    win_res_t           win;
    logic               cfg_wr;
    logic [FW:0]        j_inc, k_inc, fill_ext;

    bkc_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_delay_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    bkc_ram #(.WIDTH(FW), .DEPTH(TABLE_ENTRIES)) u_fill_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    bkc_ram #(.WIDTH(REC_W), .DEPTH(REC_DEPTH)) u_rec_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    bkc_window u_window (
        .a   (win_a),
        .b   (win_b),
        .lo  (win_lo),
        .hi  (win_hi),
        .res (win)
    );

    assign delay_rd = dvq_reg ? d_rdata : '0;
    assign fill_rd  = fvq_reg ? f_rdata : '0;
    assign rec_pair = rec_reg[REC_W-1 -: PAIR_W];
    assign rec_type = rec_reg[TIME_W +: TYPE_W];
    assign rec_time = rec_reg[TIME_W-1:0];
    assign rd_pair  = r_rdata[REC_W-1 -: PAIR_W];
    assign j_inc    = (FW+1)'(j_reg) + (FW+1)'(1);
    assign k_inc    = (FW+1)'(k_reg) + (FW+1)'(1);
    assign fill_ext = (FW+1)'(fill_reg);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_LOCAL_ADDRESS: prdata = 32'(local_address_reg);
            REG_MAX_PROP:      prdata = 32'(max_prop_reg);
            REG_CTRL_GUARD:    prdata = 32'(ctrl_guard_reg);
            REG_DATA_GUARD:    prdata = 32'(data_guard_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= LOCAL_ADDRESS_RST;
            max_prop_reg      <= MAX_PROP_RST;
            ctrl_guard_reg    <= CTRL_GUARD_RST;
            data_guard_reg    <= DATA_GUARD_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LOCAL_ADDRESS: local_address_reg <= pwdata[NIB_W-1:0];
                REG_MAX_PROP:      max_prop_reg      <= pwdata[TIME_W-1:0];
                REG_CTRL_GUARD:    ctrl_guard_reg    <= pwdata[GUARD_W-1:0];
                REG_DATA_GUARD:    data_guard_reg    <= pwdata[GUARD_W-1:0];
                default:           ;
            endcase
        end
    end

    // operand selection for the current window step
    always_comb
    begin
        win_a      = lar_reg;
        win_b      = x1_reg;
        win_lo     = ctrl_guard_reg;
        win_hi     = ctrl_guard_reg;
        stale_step = 1'b0;
        last_step  = 1'b0;
        case (rec_type)
            FT_RTS:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        win_b      = x2_reg;
                        stale_step = 1'b1;
                    end
                    3'd1: ;
                    3'd2: win_b = x2_reg;
                    3'd3: win_a = lad_reg;
                    3'd4:
                    begin
                        win_a = lad_reg;
                        win_b = x2_reg;
                    end
                    3'd5:
                    begin
                        win_a = lad_reg;
                        win_b = alc_reg;
                    end
                    default:
                    begin
                        win_a     = lad_reg;
                        win_b     = ala_reg;
                        last_step = 1'b1;
                    end
                endcase
            end
            FT_CTS:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        win_lo = data_guard_reg >> 1;
                        win_hi = data_guard_reg;
                    end
                    3'd1:
                    begin
                        win_a  = lad_reg;
                        win_lo = data_guard_reg >> 1;
                        win_hi = data_guard_reg;
                    end
                    3'd2:
                    begin
                        win_a = x2_reg;
                        win_b = alc_reg;
                    end
                    3'd3:
                    begin
                        win_a = x2_reg;
                        win_b = ala_reg;
                    end
                    default:
                    begin
                        win_b      = x2_reg;
                        stale_step = 1'b1;
                        last_step  = 1'b1;
                    end
                endcase
            end
            FT_DATA:
            begin
                case (step_reg)
                    3'd0: ;
                    3'd1: win_a = lad_reg;
                    default:
                    begin
                        stale_step = 1'b1;
                        last_step  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                stale_step = 1'b1;
                last_step  = 1'b1;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        dvalid_next      = dvalid_reg;
        fvalid_next      = fvalid_reg;
        out_valid_next   = out_valid_reg;
        pair_next        = pair_reg;
        type_next        = type_reg;
        rtime_next       = rtime_reg;
        now_next         = now_reg;
        p2_next          = p2_reg;
        p3_next          = p3_reg;
        alc_next         = alc_reg;
        ala_next         = ala_reg;
        bucket_next      = bucket_reg;
        fill_next        = fill_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        rec_next         = rec_reg;
        do_next          = do_reg;
        lar_next         = lar_reg;
        lad_next         = lad_reg;
        x1_next          = x1_reg;
        x2_next          = x2_reg;
        step_next        = step_reg;
        res_backoff_next = res_backoff_reg;
        res_status_next  = res_status_reg;
        backoff_next     = backoff_reg;
        status_next      = status_reg;

        d_we    = 1'b0;
        d_waddr = hash_of(pair_addr);
        d_wdata = delay_value;
        d_raddr = hash_of(pair_reg);
        f_we    = 1'b0;
        f_waddr = bucket_reg;
        f_wdata = fill_reg - FW'(1);
        f_raddr = bucket_reg;
        r_we    = 1'b0;
        r_waddr = rec_addr(bucket_reg, k_reg);
        r_wdata = r_rdata;
        r_raddr = rec_addr(bucket_reg, j_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pair_next        = pair_addr;
                    type_next        = frame_type;
                    rtime_next       = record_time;
                    now_next         = current_time;
                    p2_next          = max_prop_reg << 1;
                    p3_next          = max_prop_reg + (max_prop_reg << 1);
                    res_backoff_next = '0;
                    res_status_next  = 1'b0;
                    case (func)
                        FN_WRITE_DELAY:
                        begin
                            d_we                           = 1'b1;
                            dvalid_next[hash_of(pair_addr)] = 1'b1;
                            state_next                     = S_FINISH;
                        end
                        FN_ADD_RECORD:
                        begin
                            f_raddr    = hash_of(pair_addr);
                            state_next = S_ADD_WR;
                        end
                        FN_CHECK:
                        begin
                            d_raddr    = hash_of(pair_addr);
                            state_next = S_CHK1;
                        end
                        default:
                        begin
                            dvalid_next = '0;
                            fvalid_next = '0;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
            end
            S_ADD_WR:
            begin
                if (fill_rd >= FW'(RECORDS_PER_BUCKET))
                begin
                    res_status_next = 1'b1;
                end
                else
                begin
                    r_we                          = 1'b1;
                    r_waddr                       = rec_addr(hash_of(pair_reg), fill_rd);
                    r_wdata                       = {pair_reg, type_reg, rtime_reg};
                    f_we                          = 1'b1;
                    f_waddr                       = hash_of(pair_reg);
                    f_wdata                       = fill_rd + FW'(1);
                    fvalid_next[hash_of(pair_reg)] = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_CHK1:
            begin
                alc_next    = now_reg + max_prop_reg + delay_rd;
                ala_next    = now_reg + p3_reg + delay_rd;
                bucket_next = '0;
                state_next  = S_BKT;
            end
            S_BKT:
            begin
                state_next = S_FILL;
            end
            S_FILL:
            begin
                fill_next = fill_rd;
                j_next    = '0;
                if (fill_rd != '0)
                begin
                    r_raddr    = rec_addr(bucket_reg, '0);
                    state_next = S_RECB;
                end
                else if (bucket_reg == IW'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    bucket_next = bucket_reg + IW'(1);
                    state_next  = S_BKT;
                end
            end
            S_RECA:
            begin
                state_next = S_RECB;
            end
            S_RECB:
            begin
                rec_next   = r_rdata;
                d_raddr    = hash_of(rd_pair);
                state_next = S_DO;
            end
            S_DO:
            begin
                do_next    = delay_rd;
                d_raddr    = hash_of({local_address_reg, rec_pair[PAIR_W-1 -: NIB_W]});
                state_next = S_DL;
            end
            S_DL:
            begin
                lar_next  = now_reg + delay_rd;
                lad_next  = now_reg + p2_reg + delay_rd;
                x1_next   = rec_time + max_prop_reg + do_reg;
                x2_next   = (rec_type == FT_CTS) ? rec_time + p2_reg + delay_rd
                                                 : rec_time + p3_reg + do_reg;
                step_next = '0;
                if (rec_type == FT_ACK)
                begin
                    k_next     = j_reg;
                    state_next = S_RET;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (stale_step && win.stale)
                begin
                    k_next     = j_reg;
                    state_next = S_RET;
                end
                else if (!stale_step && win.hit)
                begin
                    res_backoff_next = win.backoff;
                    state_next       = S_FINISH;
                end
                else if (!last_step)
                begin
                    step_next = step_reg + 3'd1;
                end
                else
                begin
                    // record kept, move on to the next one
                    j_next = j_inc[FW-1:0];
                    if (j_inc < fill_ext)
                    begin
                        state_next = S_RECA;
                    end
                    else if (bucket_reg == IW'(TABLE_ENTRIES - 1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        bucket_next = bucket_reg + IW'(1);
                        state_next  = S_BKT;
                    end
                end
            end
            S_RET:
            begin
                if (k_inc < fill_ext)
                begin
                    r_raddr    = rec_addr(bucket_reg, k_inc[FW-1:0]);
                    state_next = S_RETW;
                end
                else
                begin
                    // shift done, drop the bucket count and rescan the same slot
                    f_we                    = 1'b1;
                    fvalid_next[bucket_reg] = 1'b1;
                    fill_next               = fill_reg - FW'(1);
                    if (j_inc < fill_ext)
                    begin
                        state_next = S_RECA;
                    end
                    else if (bucket_reg == IW'(TABLE_ENTRIES - 1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        bucket_next = bucket_reg + IW'(1);
                        state_next  = S_BKT;
                    end
                end
            end
            S_RETW:
            begin
                r_we       = 1'b1;
                k_next     = k_inc[FW-1:0];
                state_next = S_RET;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    backoff_next   = res_backoff_reg;
                    status_next    = res_status_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dvalid_reg    <= '0;
            fvalid_reg    <= '0;
            dvq_reg       <= 1'b0;
            fvq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dvalid_reg    <= dvalid_next;
            fvalid_reg    <= fvalid_next;
            dvq_reg       <= dvalid_reg[d_raddr];
            fvq_reg       <= fvalid_reg[f_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg        <= pair_next;
        type_reg        <= type_next;
        rtime_reg       <= rtime_next;
        now_reg         <= now_next;
        p2_reg          <= p2_next;
        p3_reg          <= p3_next;
        alc_reg         <= alc_next;
        ala_reg         <= ala_next;
        bucket_reg      <= bucket_next;
        fill_reg        <= fill_next;
        j_reg           <= j_next;
        k_reg           <= k_next;
        rec_reg         <= rec_next;
        do_reg          <= do_next;
        lar_reg         <= lar_next;
        lad_reg         <= lad_next;
        x1_reg          <= x1_next;
        x2_reg          <= x2_next;
        step_reg        <= step_next;
        res_backoff_reg <= res_backoff_next;
        res_status_reg  <= res_status_next;
        backoff_reg     <= backoff_next;
        status_reg      <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign backoff   = backoff_reg;
    assign status    = status_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted transaction did not start work");

    a_step_in_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> (j_reg < fill_reg) &&
                                (fill_reg <= FW'(RECORDS_PER_BUCKET)))
        else $error("record position outside bucket fill");

    a_shift_in_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RETW |-> k_inc < fill_ext)
        else $error("retire shift past bucket fill");

    a_full_no_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> backoff == '0)
        else $error("bucket full flag with nonzero backoff");

    a_finish_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && (!out_valid_reg || !out_stall) |=> out_valid_reg)
        else $error("result not presented");

endmodule

FILE: bench/mac_collision_backoff_checker_test.sv
// testbench for the collision backoff checker: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module mac_collision_backoff_checker_test;
    import bkc_pkg::*;

    localparam int IDLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int ENTRIES      = TABLE_ENTRIES_DEF;
    localparam int DEPTH        = RECORDS_PER_BUCKET_DEF;

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [TYPE_W-1:0] ftype;
        logic [TIME_W-1:0] stamp;
    } heard_frame_t;

    typedef struct packed {
        logic [1:0]           fn;
        logic [PAIR_W-1:0]    pair;
        logic [TYPE_W-1:0]    ftype;
        logic [TIME_W-1:0]    rtime;
        logic [TIME_W-1:0]    now;
        logic [TIME_W-1:0]    dval;
        logic                 fixed;
        logic [BACKOFF_W-1:0] fixed_backoff;
        logic                 fixed_full;
    } stim_row_t;

    typedef struct packed {
        logic [BACKOFF_W-1:0] backoff;
        logic                 full;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [PAIR_W-1:0] pair_addr = '0;
    logic [TYPE_W-1:0] frame_type = '0;
    logic [TIME_W-1:0] record_time = '0, current_time = '0, delay_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [BACKOFF_W-1:0] backoff;
    logic status;

    mac_collision_backoff_checker u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .pair_addr(pair_addr), .frame_type(frame_type),
        .record_time(record_time), .current_time(current_time),
        .delay_value(delay_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .backoff(backoff), .status(status)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [NIB_W-1:0]   my_addr;
    logic [TIME_W-1:0]  prop;
    logic [GUARD_W-1:0] ctrl_guard;
    logic [GUARD_W-1:0] data_guard;
    logic [TIME_W-1:0]  delays [ENTRIES];
    heard_frame_t       heard [ENTRIES][DEPTH];
    int                 fill [ENTRIES];

    verdict_t pending [$];
    int  errors = 0;
    bit  hold_req = 1'b0;
    int  idle_count = 0;

    // burst pacing of the sender
    int burst_left = 0;

    function automatic logic [7:0] pair_slot(logic [PAIR_W-1:0] p);
        // (s-1)*NODES + d - 2, wrapped to the table size
        return p - 8'(NODES_DEF + 2);
    endfunction

    function automatic int wrap_diff(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] x;
        x = a - b;
        return int'($signed(x));
    endfunction

    function automatic int window_hit(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b,
                                      int lo, int hi);
        int d;
        d = wrap_diff(a, b);
        if (d >= -lo && d <= hi)
            return hi - d + 5;
        return 0;
    endfunction

    function automatic int frame_backoff(heard_frame_t f, logic [PAIR_W-1:0] plan,
                                          logic [TIME_W-1:0] now, output bit drop);
        logic [TIME_W-1:0] dl, dother, dd, lar, lad, alc, ala, ta, tb;
        int gc, gd, b;
        gc = int'(ctrl_guard);
        gd = int'(data_guard);
        dl = delays[pair_slot({my_addr, f.pair[7:4]})];
        dother = delays[pair_slot(f.pair)];
        dd = delays[pair_slot(plan)];
        lar = now + dl;
        lad = TIME_W'(now + 2 * prop + dl);
        alc = now + prop + dd;
        ala = TIME_W'(now + 3 * prop + dd);
        drop = 1'b0;
        case (f.ftype)
            FT_RTS:
            begin
                ta = f.stamp + prop + dother;
                tb = TIME_W'(f.stamp + 3 * prop + dother);
                if (wrap_diff(lar, tb) > gc)
                begin
                    drop = 1'b1;
                    return 0;
                end
                b = window_hit(lar, ta, gc, gc); if (b != 0) return b;
                b = window_hit(lar, tb, gc, gc); if (b != 0) return b;
                b = window_hit(lad, ta, gc, gc); if (b != 0) return b;
                b = window_hit(lad, tb, gc, gc); if (b != 0) return b;
                b = window_hit(lad, alc, gc, gc); if (b != 0) return b;
                return window_hit(lad, ala, gc, gc);
            end
            FT_CTS:
            begin
                ta = f.stamp + prop + dother;
                tb = TIME_W'(f.stamp + 2 * prop + dl);
                b = window_hit(lar, ta, gd / 2, gd); if (b != 0) return b;
                b = window_hit(lad, ta, gd / 2, gd); if (b != 0) return b;
                b = window_hit(tb, alc, gc, gc); if (b != 0) return b;
                b = window_hit(tb, ala, gc, gc); if (b != 0) return b;
                drop = wrap_diff(lar, tb) > gc;
                return 0;
            end
            FT_DATA:
            begin
                ta = f.stamp + prop + dother;
                b = window_hit(lar, ta, gc, gc); if (b != 0) return b;
                b = window_hit(lad, ta, gc, gc); if (b != 0) return b;
                drop = wrap_diff(lar, ta) > gc;
                return 0;
            end
            default:
            begin
                drop = 1'b1;
                return 0;
            end
        endcase
    endfunction

    function automatic int scan_backoff(logic [PAIR_W-1:0] plan, logic [TIME_W-1:0] now);
        int j, b;
        bit drop;
        for (int i = 0; i < ENTRIES; i++)
        begin
            j = 0;
            while (j < fill[i])
            begin
                b = frame_backoff(heard[i][j], plan, now, drop);
                if (b != 0)
                    return b;
                if (drop)
                begin
                    for (int k = j; k + 1 < fill[i]; k++)
                        heard[i][k] = heard[i][k + 1];
                    fill[i]--;
                end
                else
                    j++;
            end
        end
        return 0;
    endfunction

    function automatic verdict_t apply_item(stim_row_t r);
        verdict_t v;
        logic [7:0] h;
        v = '0;
        h = pair_slot(r.pair);
        case (r.fn)
            FN_WRITE_DELAY: delays[h] = r.dval;
            FN_ADD_RECORD:
            begin
                if (fill[h] >= DEPTH)
                    v.full = 1'b1;
                else
                begin
                    heard[h][fill[h]] = '{r.pair, r.ftype, r.rtime};
                    fill[h]++;
                end
            end
            FN_CHECK: v.backoff = BACKOFF_W'(scan_backoff(r.pair, r.now));
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    delays[i] = '0;
                    fill[i] = 0;
                end
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LOCAL_ADDRESS: my_addr = value[NIB_W-1:0];
            REG_MAX_PROP:      prop = value[TIME_W-1:0];
            REG_CTRL_GUARD:    ctrl_guard = value[GUARD_W-1:0];
            default:           data_guard = value[GUARD_W-1:0];
        endcase
    endtask

    task automatic set_config(logic [3:0] la, logic [15:0] p, logic [14:0] gc,
                              logic [14:0] gd);
        write_reg(REG_LOCAL_ADDRESS, 32'(la));
        write_reg(REG_MAX_PROP, 32'(p));
        write_reg(REG_CTRL_GUARD, 32'(gc));
        write_reg(REG_DATA_GUARD, 32'(gd));
    endtask

    task automatic send(stim_row_t r);
        int gap;
        verdict_t v;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        func <= r.fn; pair_addr <= r.pair; frame_type <= r.ftype;
        record_time <= r.rtime; current_time <= r.now; delay_value <= r.dval;
        do
            @(posedge clk);
        while (in_stall);
        v = apply_item(r);
        if (r.fixed)
            v = '{r.fixed_backoff, r.fixed_full};
        pending.push_back(v);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // nibbles from a small pool so buckets and delay entries get reused
    function automatic logic [3:0] near_node();
        return ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
    endfunction

    task automatic random_phase(int count);
        stim_row_t r;
        logic [15:0] base;
        int pick;
        base = 16'($urandom);
        for (int n = 0; n < count; n++)
        begin
            r = '0;
            pick = $urandom_range(0, 99);
            base += 16'($urandom_range(0, 300));
            r.pair = {near_node(), near_node()};
            r.ftype = 2'($urandom);
            r.rtime = base + 16'($urandom_range(0, 600)) - 16'd300;
            r.now = base + 16'($urandom_range(0, 600)) - 16'd300;
            r.dval = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 2000));
            if (pick < 15)
                r.fn = FN_WRITE_DELAY;
            else if (pick < 55)
                r.fn = FN_ADD_RECORD;
            else if (pick < 87)
                r.fn = FN_CHECK;
            else if (pick < 89)
                r.fn = FN_CLEAR_ALL;
            else
            begin
                // noise over the whole pair, time and delay ranges, func without clear all
                r.fn = 2'($urandom_range(0, 2));
                r.pair = 8'($urandom);
                r.rtime = 16'($urandom);
                r.now = 16'($urandom);
                r.dval = 16'($urandom);
            end
            send(r);
        end
    endtask

    localparam stim_row_t DIRECTED [20] = '{
        '{FN_CHECK,       8'h12, FT_RTS,  16'd0,     16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_WRITE_DELAY, 8'h00, FT_RTS,  16'd0,     16'd0,     16'hffff,  1'b1, 17'd0, 1'b0},
        '{FN_WRITE_DELAY, 8'hff, FT_ACK,  16'hffff,  16'hffff,  16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_WRITE_DELAY, 8'h21, FT_RTS,  16'd0,     16'd0,     16'd50,    1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h21, FT_RTS,  16'd0,     16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h21, FT_CTS,  16'd1000,  16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h21, FT_DATA, 16'hffff,  16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h21, FT_ACK,  16'd500,   16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h21, FT_RTS,  16'd10,    16'd0,     16'd0,     1'b1, 17'd0, 1'b1},
        '{FN_CHECK,       8'h12, FT_RTS,  16'd0,     16'hfc18,  16'd0,     1'b0, 17'd0, 1'b0},
        '{FN_CHECK,       8'hff, FT_RTS,  16'd0,     16'hffff,  16'd0,     1'b0, 17'd0, 1'b0},
        '{FN_CHECK,       8'h00, FT_RTS,  16'd0,     16'd0,     16'd0,     1'b0, 17'd0, 1'b0},
        '{FN_CLEAR_ALL,   8'h5a, FT_CTS,  16'h5555,  16'haaaa,  16'h5555,  1'b1, 17'd0, 1'b0},
        '{FN_CHECK,       8'h21, FT_RTS,  16'd0,     16'd1234,  16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_WRITE_DELAY, 8'h10, FT_RTS,  16'd0,     16'd0,     16'd300,   1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h00, FT_DATA, 16'd1500,  16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'hf0, FT_RTS,  16'hffff,  16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_ADD_RECORD,  8'h31, FT_CTS,  16'd64000, 16'd0,     16'd0,     1'b1, 17'd0, 1'b0},
        '{FN_CHECK,       8'h00, FT_RTS,  16'd0,     16'd2200,  16'd0,     1'b0, 17'd0, 1'b0},
        '{FN_CHECK,       8'h31, FT_RTS,  16'd0,     16'hfff0,  16'd0,     1'b0, 17'd0, 1'b0}
    };

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        int mode, left, hold;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (hold = 1; hold < HOLD_CYCLES; hold++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= (left % 4 != 0);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("mac_collision_backoff_checker_test NOT OK");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (pending.size() == 0)
                begin
                    $display("%0t: unexpected transaction backoff=%0d status=%0d",
                             $time, backoff, status);
                    errors++;
                end
                else
                begin
                    want = pending.pop_front();
                    if (backoff !== want.backoff)
                    begin
                        $display("%0t: backoff expected %0d actual %0d",
                                 $time, want.backoff, backoff);
                        errors++;
                    end
                    if (status !== want.full)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.full, status);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        my_addr = LOCAL_ADDRESS_RST;
        prop = MAX_PROP_RST;
        ctrl_guard = CTRL_GUARD_RST;
        data_guard = DATA_GUARD_RST;
        for (int i = 0; i < ENTRIES; i++)
        begin
            delays[i] = '0;
            fill[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send(DIRECTED[i]);
        random_phase(100);
        drain();

        // extremes: everything zero, then everything at maximum
        set_config(4'd0, 16'd0, 15'd0, 15'd0);
        random_phase(80);
        drain();
        set_config(4'd15, 16'hffff, 15'h7fff, 15'h7fff);
        hold_req = 1'b1;
        random_phase(100);
        drain();
        set_config(4'd3, 16'd300, 15'd50, 15'd81);
        random_phase(140);
        drain();
        set_config(4'($urandom), 16'($urandom_range(0, 2000)),
                   15'($urandom_range(0, 400)), 15'($urandom_range(0, 600)));
        random_phase(140);
        drain();

        if (errors == 0)
            $display("mac_collision_backoff_checker_test OK");
        else
            $display("mac_collision_backoff_checker_test NOT OK");
        $finish;
    end

endmodule
